// ===== src/iwds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iwds_pkg;

	// tick counter width default
	localparam int IWDS_TICK_BITS = 17;

	// configuration port
	localparam int IWDS_IDX_W  = 3;
	localparam int IWDS_DATA_W = 16;

	typedef enum logic [IWDS_IDX_W-1:0] {
		REG_SPEED_REF = 3'd0,
		REG_PREFIX    = 3'd1,
		REG_OFFSET    = 3'd2,
		REG_STEP      = 3'd3,
		REG_GAP       = 3'd4
	} iwds_reg_t;

	localparam logic [7:0]  IWDS_RST_SPEED_REF = 8'd70;
	localparam logic [15:0] IWDS_RST_PREFIX    = 16'd500;
	localparam logic [15:0] IWDS_RST_OFFSET    = 16'd1500;
	localparam logic [9:0]  IWDS_RST_STEP      = 10'd200;
	localparam logic [15:0] IWDS_RST_GAP       = 16'd55000;

	// divide by three for values below 256: (x * 171) >> 9
	localparam logic [15:0] IWDS_DIV3_MUL   = 16'd171;
	localparam int          IWDS_DIV3_SHIFT = 9;

	// unsaturated data pulse length: (mag + 1) * step + offset
	localparam int IWDS_RAW_W = 19;

	typedef struct packed {
		logic [7:0]  speed_reference;
		logic [15:0] prefix_ticks;
		logic [15:0] offset_ticks;
		logic [9:0]  step_ticks;
		logic [15:0] gap_ticks;
	} iwds_cfg_t;

	// classified word between front and back
	typedef struct packed {
		logic mode;
		logic neg;
	} iwds_cls_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic dropped;
	} iwds_res_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_PREFIX_ON  = 5'b00010,
		PH_PREFIX_OFF = 5'b00100,
		PH_DATA       = 5'b01000,
		PH_GAP        = 5'b10000
	} iwds_phase_t;

endpackage

`default_nettype wire

// ===== src/iwds_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iwds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== src/iwds_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iwds_front #(
	parameter int TICK_COUNTER_BITS = iwds_pkg::IWDS_TICK_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic                        mode,
	input  wire logic                        swipe_left,
	input  wire logic [7:0]                  speed,
	input  wire iwds_pkg::iwds_cfg_t         cfg,
	output logic                             item_valid,
	input  wire logic                        item_ready,
	output iwds_pkg::iwds_cls_t              item_cls,
	output logic [TICK_COUNTER_BITS-1:0]     item_pulse
);
	import iwds_pkg::*;

	localparam int N  = TICK_COUNTER_BITS;
	localparam int SW = (N > IWDS_RAW_W) ? N : IWDS_RAW_W;
	localparam logic [SW-1:0] CAP = SW'((64'd1 << N) - 64'd1);

	logic        v_s1, v_s2;
	logic        adv_s1, adv_s2;
	logic        mode_s1, neg_s1;
	logic [6:0]  mag_s1;
	iwds_cls_t   cls_s2;
	logic [N-1:0] pulse_s2;

	logic [8:0]  diff;
	logic        diff_neg;
	logic [7:0]  abs_diff;
	logic [15:0] div_prod;
	logic [6:0]  mag;
	logic [7:0]  mag_p1;
	logic [17:0] scaled;
	logic [IWDS_RAW_W-1:0] raw;
	logic [SW-1:0] raw_w;

	// stage 1: |reference - speed| / 3 and sign of the delta
	always_comb begin
		diff     = {1'b0, cfg.speed_reference} - {1'b0, speed};
		diff_neg = diff[8];
		abs_diff = diff_neg ? 8'(-diff) : diff[7:0];
		div_prod = 16'(abs_diff) * IWDS_DIV3_MUL;
		mag      = 7'(div_prod >> IWDS_DIV3_SHIFT);
	end

	// stage 2: data pulse length, saturated to the counter
	always_comb begin
		mag_p1 = 8'({1'b0, mag_s1}) + 8'd1;
		scaled = 18'(mag_p1) * 18'(cfg.step_ticks);
		raw    = IWDS_RAW_W'(scaled) + IWDS_RAW_W'(cfg.offset_ticks);
		raw_w  = SW'(raw);
	end

	assign adv_s2     = !v_s2 || item_ready;
	assign adv_s1     = !v_s1 || adv_s2;
	assign full       = !adv_s1;
	assign item_valid = v_s2;
	assign item_cls   = cls_s2;
	assign item_pulse = pulse_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= push;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && push) begin
			mode_s1 <= mode;
			mag_s1  <= mag;
			neg_s1  <= (mag != '0) && (diff_neg ^ swipe_left);
		end
		if (adv_s2 && v_s1) begin
			cls_s2.mode <= mode_s1;
			cls_s2.neg  <= neg_s1;
			pulse_s2    <= N'((raw_w > CAP) ? CAP : raw_w);
		end
	end

endmodule

`default_nettype wire

// ===== src/iwds_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iwds_back #(
	parameter int TICK_COUNTER_BITS = iwds_pkg::IWDS_TICK_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire iwds_pkg::iwds_cfg_t         cfg,
	input  wire logic                        item_valid,
	output logic                             item_pop,
	input  wire iwds_pkg::iwds_cls_t         item_cls,
	input  wire logic [TICK_COUNTER_BITS-1:0] item_pulse,
	input  wire logic                        res_full,
	output logic                             res_push,
	output iwds_pkg::iwds_res_t              res
);
	import iwds_pkg::*;

	localparam int N = TICK_COUNTER_BITS;

	iwds_phase_t  phase_q, phase_d;
	logic [N-1:0] cnt_q, cnt_d;
	logic [N-1:0] plen_q, plen_d;

	logic         take;
	logic         carrier_cur;
	logic         busy_cur;
	iwds_phase_t  succ;
	iwds_phase_t  start;
	iwds_phase_t  ent_ph;
	logic [N-1:0] pre_len, gap_len, dlen, ent_cnt;

	function automatic iwds_phase_t next_of(input iwds_phase_t p);
		iwds_phase_t r;
		unique case (p)
			PH_PREFIX_ON:  r = PH_PREFIX_OFF;
			PH_PREFIX_OFF: r = PH_DATA;
			PH_DATA:       r = PH_GAP;
			default:       r = PH_IDLE;
		endcase
		return r;
	endfunction

	// first phase from st on whose length is not zero
	function automatic iwds_phase_t enter_ph(input iwds_phase_t st, input logic pre_nz,
			input logic dat_nz, input logic gap_nz);
		iwds_phase_t r;
		r = PH_IDLE;
		priority if ((st == PH_PREFIX_ON || st == PH_PREFIX_OFF) && pre_nz) begin
			r = st;
		end else if ((st == PH_PREFIX_ON || st == PH_PREFIX_OFF || st == PH_DATA) && dat_nz) begin
			r = PH_DATA;
		end else if (st != PH_IDLE && gap_nz) begin
			r = PH_GAP;
		end else begin
			r = PH_IDLE;
		end
		return r;
	endfunction

	assign take     = item_valid && !res_full;
	assign item_pop = take;
	assign res_push = take;

	always_comb begin
		carrier_cur = (phase_q == PH_PREFIX_ON) || (phase_q == PH_DATA);
		busy_cur    = (phase_q != PH_IDLE);
		succ        = next_of(phase_q);
		pre_len     = N'(cfg.prefix_ticks);
		gap_len     = N'(cfg.gap_ticks);
		start       = item_cls.mode ? (item_cls.neg ? PH_PREFIX_ON : PH_DATA) : succ;
		dlen        = item_cls.mode ? item_pulse : plen_q;
		ent_ph      = enter_ph(start, pre_len != '0, dlen != '0, gap_len != '0);
		unique case (ent_ph)
			PH_PREFIX_ON, PH_PREFIX_OFF: ent_cnt = pre_len;
			PH_DATA:                     ent_cnt = dlen;
			PH_GAP:                      ent_cnt = gap_len;
			default:                     ent_cnt = '0;
		endcase

		phase_d = phase_q;
		cnt_d   = cnt_q;
		plen_d  = plen_q;
		res     = '{carrier_on: carrier_cur, busy_res: busy_cur, dropped: 1'b0};
		if (!item_cls.mode) begin
			if (busy_cur) begin
				if (cnt_q > N'(1)) begin
					cnt_d = cnt_q - N'(1);
				end else begin
					phase_d = ent_ph;
					cnt_d   = ent_cnt;
				end
			end
		end else if (busy_cur) begin
			res.dropped = 1'b1;
		end else begin
			plen_d  = item_pulse;
			phase_d = ent_ph;
			cnt_d   = ent_cnt;
			res.carrier_on = (ent_ph == PH_PREFIX_ON) || (ent_ph == PH_DATA);
			res.busy_res   = (ent_ph != PH_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			plen_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			plen_q  <= plen_d;
		end
	end

`ifndef SYNTHESIS
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (cnt_q != '0))
		else $error("running phase with empty tick count");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.dropped) |-> (res.busy_res && phase_q != PH_IDLE))
		else $error("word dropped while idle");

	a_load_len: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_cls.mode && phase_q == PH_IDLE) |=> (plen_q == $past(item_pulse)))
		else $error("pulse length not loaded on frame start");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item_cls.mode && phase_q != PH_IDLE && cnt_q > N'(1))
		|=> (cnt_q == $past(cnt_q) - N'(1) && phase_q == $past(phase_q)))
		else $error("tick did not count down");
`endif

endmodule

`default_nettype wire

// ===== src/ir_pulse_width_delta_sender.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Infrared pulse-width delta sender.
// Input channel (push/full): one word per cycle while full is low, each either a microsecond tick
// (mode 0) or a slider event (mode 1, with swipe_left and speed). A word is taken
// at a clock edge with push high and full low.
// Result channel (empty/pop): exactly one word per input word, in order. While
// empty is low the oldest result sits on carrier_on, busy_res and dropped; it
// leaves at an edge with pop high.
// Throughput: one word per cycle while the result queue has room, set by the phase
// and tick-count update in the back end. On its way a word passes the two front
// stages and the classified-word queue; the back end writes the result queue in
// the same cycle that it takes the word.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// indexes beyond the list are ignored. Write only while no word is in flight.
// Reset: registers return to their defaults, the sender goes idle, queues empty.
// Stall: with pop low the result queue fills, the back end holds, the middle
// queue and front stages fill and full rises; no word is lost or repeated.
module ir_pulse_width_delta_sender #(
	parameter int TICK_COUNTER_BITS = iwds_pkg::IWDS_TICK_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [iwds_pkg::IWDS_IDX_W-1:0]  cfg_index,
	input  wire logic [iwds_pkg::IWDS_DATA_W-1:0] cfg_data,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             mode,
	input  wire logic                             swipe_left,
	input  wire logic [7:0]                       speed,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  carrier_on,
	output logic                                  busy_res,
	output logic                                  dropped
);
	import iwds_pkg::*;

	localparam int N  = TICK_COUNTER_BITS;
	localparam int MW = N + $bits(iwds_cls_t);
	localparam int RW = $bits(iwds_res_t);

	iwds_cfg_t    cfg_q;

	logic         fr_valid;
	logic         mid_full;
	iwds_cls_t    fr_cls;
	logic [N-1:0] fr_pulse;

	logic [MW-1:0] mid_rdata;
	logic          mid_empty;
	logic          mid_pop;
	iwds_cls_t     bk_cls;
	logic [N-1:0]  bk_pulse;

	logic          res_full;
	logic          res_push;
	iwds_res_t     bk_res;
	logic [RW-1:0] res_rdata;
	iwds_res_t     out_res;

	// configuration registers; write takes effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_reference <= IWDS_RST_SPEED_REF;
			cfg_q.prefix_ticks    <= IWDS_RST_PREFIX;
			cfg_q.offset_ticks    <= IWDS_RST_OFFSET;
			cfg_q.step_ticks      <= IWDS_RST_STEP;
			cfg_q.gap_ticks       <= IWDS_RST_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_REF: cfg_q.speed_reference <= cfg_data[7:0];
				REG_PREFIX:    cfg_q.prefix_ticks    <= cfg_data;
				REG_OFFSET:    cfg_q.offset_ticks    <= cfg_data;
				REG_STEP:      cfg_q.step_ticks      <= cfg_data[9:0];
				REG_GAP:       cfg_q.gap_ticks       <= cfg_data;
				default:       ; // unknown index: drop the write
			endcase
		end
	end

	// front: classify the word and work out the data pulse length
	iwds_front #(.TICK_COUNTER_BITS(N)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.swipe_left (swipe_left),
		.speed      (speed),
		.cfg        (cfg_q),
		.item_valid (fr_valid),
		.item_ready (!mid_full),
		.item_cls   (fr_cls),
		.item_pulse (fr_pulse)
	);

	// short queue between front and back
	iwds_fifo #(.WIDTH(MW), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_valid),
		.wdata  ({fr_cls, fr_pulse}),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign bk_cls   = mid_rdata[MW-1 -: $bits(iwds_cls_t)];
	assign bk_pulse = mid_rdata[N-1:0];

	// back: phase sequencer and tick counter
	iwds_back #(.TICK_COUNTER_BITS(N)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (!mid_empty),
		.item_pop   (mid_pop),
		.item_cls   (bk_cls),
		.item_pulse (bk_pulse),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (bk_res)
	);

	// result queue; hold results while the receiver stalls
	iwds_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (bk_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign out_res    = res_rdata;
	assign carrier_on = out_res.carrier_on;
	assign busy_res   = out_res.busy_res;
	assign dropped    = out_res.dropped;

endmodule

`default_nettype wire

// ===== verif/tb_ir_pulse_width_delta_sender.sv =====
`timescale 1ns / 1ps

module tb_ir_pulse_width_delta_sender;

	import iwds_pkg::*;

	localparam int     TICK_BITS   = IWDS_TICK_BITS;
	localparam longint TICK_MAX    = (longint'(1) << TICK_BITS) - 1;
	// result latency of the sender, and the settle time allowed before a write
	localparam int     LATENCY     = 3;
	localparam int     SETTLE      = 2 * LATENCY;
	localparam int     LONG_HOLD   = 60;
	localparam int     RAND_PHASES = 4;
	localparam int     RAND_WORDS  = 80;
	localparam int     OPEN_TICKS  = 40;
	// watchdog limit, with a wide margin over a passing run
	localparam longint LIMIT       = 200_000;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_EVENT  = 1'b1;
	localparam logic SWIPE_RIGHT = 1'b0;
	localparam logic SWIPE_LEFT  = 1'b1;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IWDS_IDX_W-1:0]  cfg_index;
	logic [IWDS_DATA_W-1:0] cfg_data;
	logic                   push;
	logic                   full;
	logic                   mode;
	logic                   swipe_left;
	logic [7:0]             speed;
	logic                   empty;
	logic                   pop;
	logic                   carrier_on;
	logic                   busy_res;
	logic                   dropped;

	// set by the stimulus to ask the result side for one long hold-off
	bit     hold_asked = 1'b0;
	// set for the last part of the run: no idling on either side
	bit     calm = 1'b0;
	longint cycle_count = 0;

	// Frame tracker: mirrors the sender's timing registers and phase state,
	// works out the carrier level word for every accepted input word and keeps
	// the levels still due from the block in arrival order.
	class ir_frame_board;
		logic [7:0]  speed_ref;
		logic [15:0] prefix_len;
		logic [15:0] offset_len;
		logic [9:0]  step_len;
		logic [15:0] gap_len;
		iwds_phase_t phase;
		longint      ticks_left;
		longint      pulse_len;
		iwds_res_t   levels_due[$];
		int          errors;

		function new();
			speed_ref  = IWDS_RST_SPEED_REF;
			prefix_len = IWDS_RST_PREFIX;
			offset_len = IWDS_RST_OFFSET;
			step_len   = IWDS_RST_STEP;
			gap_len    = IWDS_RST_GAP;
			phase      = PH_IDLE;
			ticks_left = 0;
			pulse_len  = 0;
			errors     = 0;
		endfunction

		function void cfg_write(logic [IWDS_IDX_W-1:0] idx, logic [IWDS_DATA_W-1:0] data);
			case (idx)
				REG_SPEED_REF: speed_ref  = data[7:0];
				REG_PREFIX:    prefix_len = data;
				REG_OFFSET:    offset_len = data;
				REG_STEP:      step_len   = data[9:0];
				REG_GAP:       gap_len    = data;
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			return (v > TICK_MAX) ? TICK_MAX : v;
		endfunction

		function longint phase_len(iwds_phase_t p);
			case (p)
				PH_PREFIX_ON, PH_PREFIX_OFF: return clip(prefix_len);
				PH_DATA:                     return pulse_len;
				PH_GAP:                      return clip(gap_len);
				default:                     return 0;
			endcase
		endfunction

		function iwds_phase_t next_phase(iwds_phase_t p);
			case (p)
				PH_PREFIX_ON:  return PH_PREFIX_OFF;
				PH_PREFIX_OFF: return PH_DATA;
				PH_DATA:       return PH_GAP;
				default:       return PH_IDLE;
			endcase
		endfunction

		// enter a phase and skip straight past any that last zero ticks
		function void enter_phase(iwds_phase_t p);
			phase      = p;
			ticks_left = phase_len(p);
			while (phase != PH_IDLE && ticks_left == 0) begin
				phase      = next_phase(phase);
				ticks_left = phase_len(phase);
			end
		endfunction

		function logic lit();
			return (phase == PH_PREFIX_ON || phase == PH_DATA);
		endfunction

		function void note_word(logic m, logic left, logic [7:0] spd);
			iwds_res_t lvl;
			int        q;
			int        delta;
			longint    mag;
			lvl.dropped = 1'b0;
			if (m == MODE_TICK) begin
				// level during the tick, then count it off
				lvl.carrier_on = lit();
				lvl.busy_res   = (phase != PH_IDLE);
				if (phase != PH_IDLE) begin
					if (ticks_left > 0)
						ticks_left--;
					if (ticks_left == 0)
						enter_phase(next_phase(phase));
				end
			end else if (phase != PH_IDLE) begin
				lvl.carrier_on = lit();
				lvl.busy_res   = 1'b1;
				lvl.dropped    = 1'b1;
			end else begin
				// signed division truncates toward zero
				q         = (int'(speed_ref) - int'(spd)) / 3;
				delta     = (left == SWIPE_LEFT) ? -q : q;
				mag       = (delta < 0) ? -delta : delta;
				pulse_len = clip((mag + 1) * longint'(step_len) + longint'(offset_len));
				enter_phase((delta < 0) ? PH_PREFIX_ON : PH_DATA);
				lvl.carrier_on = lit();
				lvl.busy_res   = (phase != PH_IDLE);
			end
			levels_due.push_back(lvl);
		endfunction

		function void check_word(logic c, logic b, logic d);
			iwds_res_t due;
			if (levels_due.size() == 0) begin
				$error("level word with nothing due: carrier_on %0b busy_res %0b dropped %0b",
					c, b, d);
				errors++;
				return;
			end
			due = levels_due.pop_front();
			if (c !== due.carrier_on) begin
				$error("carrier_on: expected %0b, actual %0b", due.carrier_on, c);
				errors++;
			end
			if (b !== due.busy_res) begin
				$error("busy_res: expected %0b, actual %0b", due.busy_res, b);
				errors++;
			end
			if (d !== due.dropped) begin
				$error("dropped: expected %0b, actual %0b", due.dropped, d);
				errors++;
			end
		endfunction

		function int pending();
			return levels_due.size();
		endfunction
	endclass

	ir_frame_board board = new();

	ir_pulse_width_delta_sender dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.swipe_left (swipe_left),
		.speed      (speed),
		.empty      (empty),
		.pop        (pop),
		.carrier_on (carrier_on),
		.busy_res   (busy_res),
		.dropped    (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: give up on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("** ir_pulse_width_delta_sender: FAILED **");
			$finish;
		end
	end

	// Check every level word as it leaves the block. Outputs are sampled at the
	// rising edge, before the block's own updates for that edge land.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_word(carrier_on, busy_res, dropped);
	end

	// Result side: pop in random bursts of stalls, plus one long hold-off on
	// request, counted here so the sender keeps offering words meanwhile.
	initial begin
		int stall;
		stall = 0;
		pop   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked) begin
				hold_asked = 1'b0;
				stall      = LONG_HOLD;
			end else if (stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 10);
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Hold push low and scramble the payload so it is seen as ignored.
	task automatic rest(int n);
		repeat (n) begin
			@(negedge clk);
			push       <= 1'b0;
			mode       <= 1'($urandom);
			swipe_left <= 1'($urandom);
			speed      <= 8'($urandom);
		end
	endtask

	// Offer one word and hold it until the block takes it.
	task automatic send_word(logic m, logic left, logic [7:0] spd);
		if (!calm && $urandom_range(0, 9) == 0)
			rest($urandom_range(1, 10));
		@(negedge clk);
		push       <= 1'b1;
		mode       <= m;
		swipe_left <= left;
		speed      <= spd;
		do
			@(posedge clk);
		while (full);
		board.note_word(m, left, spd);
	endtask

	// Tick until the current frame, gap included, has run out.
	task automatic finish_frame();
		while (board.phase != PH_IDLE)
			send_word(MODE_TICK, 1'($urandom), 8'($urandom));
	endtask

	// Stop offering and wait for every level word still due, then let the
	// pipeline settle.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [IWDS_IDX_W-1:0] idx, logic [IWDS_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.cfg_write(idx, data);
	endtask

	// Bring the sender to rest, then load a full timing set. Spare upper data
	// bits of the narrow registers carry noise, which must be dropped.
	task automatic load_timing(logic [7:0] ref_speed, logic [15:0] prefix,
		logic [15:0] offset, logic [9:0] step, logic [15:0] gap);
		finish_frame();
		drain();
		write_reg(REG_SPEED_REF, {8'($urandom), ref_speed});
		write_reg(REG_PREFIX, prefix);
		write_reg(REG_OFFSET, offset);
		write_reg(REG_STEP, {6'($urandom), step});
		write_reg(REG_GAP, gap);
	endtask

	// Random word: mostly ticks; events often near the reference speed so
	// frames stay short and many get through start to finish.
	task automatic random_word();
		logic [7:0] spd;
		int         near;
		if ($urandom_range(0, 1) == 0) begin
			near = int'(board.speed_ref) + int'($urandom_range(0, 24)) - 12;
			if (near < 0)
				near = 0;
			if (near > 255)
				near = 255;
			spd = near[7:0];
		end else begin
			spd = 8'($urandom);
		end
		send_word(($urandom_range(0, 3) == 0) ? MODE_EVENT : MODE_TICK,
			1'($urandom), spd);
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		push       = 1'b0;
		mode       = MODE_TICK;
		swipe_left = SWIPE_RIGHT;
		speed      = 8'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Short phase lengths, reference speed left at its reset value: a left
		// swipe at standstill gives a negative delta, so the frame opens with the
		// sign prefix; an event mid-frame must be dropped.
		write_reg(REG_PREFIX, 16'd3);
		write_reg(REG_OFFSET, 16'd4);
		write_reg(REG_STEP, 16'd2);
		write_reg(REG_GAP, 16'd5);
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd0);
		repeat (3) send_word(MODE_TICK, SWIPE_RIGHT, 8'd255);
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd255);
		finish_frame();

		// Every phase zero long: each event leaves the sender idle at once.
		// Indexes past the register list must change nothing.
		load_timing(8'd0, 16'd0, 16'd0, 10'd0, 16'd0);
		for (int i = int'(REG_GAP) + 1; i < (1 << IWDS_IDX_W); i++)
			write_reg(IWDS_IDX_W'(i), 16'($urandom));
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd0);
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd255);
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd255);
		send_word(MODE_TICK, SWIPE_LEFT, 8'd0);

		// Top reference speed: largest magnitude both ways, shortest prefix.
		load_timing(8'd255, 16'd1, 16'd0, 10'd1, 16'd2);
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd255);
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd0);
		finish_frame();
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd0);
		finish_frame();
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd0);
		finish_frame();

		// Small reference: negative differences truncate toward zero, so some
		// give no prefix and some the sign prefix.
		load_timing(8'd3, 16'd3, 16'd2, 10'd1, 16'd0);
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd10);
		finish_frame();
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd4);
		finish_frame();
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd5);
		finish_frame();
		send_word(MODE_EVENT, SWIPE_LEFT, 8'd0);

		// Random traffic over several short timing sets. Ask for one long
		// hold-off on the result side, and once pause until all words are back.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			load_timing(8'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
				10'($urandom_range(0, 3)), 16'($urandom_range(0, 8)));
			for (int n = 0; n < RAND_WORDS; n++) begin
				if (ph == 1 && n == 40)
					hold_asked = 1'b1;
				if (ph == 2 && n == RAND_WORDS / 2)
					drain();
				random_word();
			end
		end

		// Last part, no idling: every register at its top, so the data pulse
		// overflows the tick counter and saturates; run the opening ticks only.
		calm = 1'b1;
		load_timing(8'd255, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF);
		send_word(MODE_EVENT, SWIPE_RIGHT, 8'd0);
		repeat (OPEN_TICKS) send_word(MODE_TICK, 1'($urandom), 8'($urandom));
		drain();

		if (board.errors == 0 && board.pending() == 0)
			$display("** ir_pulse_width_delta_sender: PASSED **");
		else
			$display("** ir_pulse_width_delta_sender: FAILED **");
		$finish;
	end

endmodule
